// ----- rtl/utf8w_pkg.sv -----
// Shared constants, types and the code point weight function for the display width core.
package utf8w_pkg;

   // Running total width; the total saturates at 2^TOTAL_BITS - 1.
   localparam int TOTAL_BITS = 20;
   localparam int RESULT_BITS = 20;
   localparam int POINT_BITS = 21;
   localparam int DELTA_BITS = 3;

   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_CODE = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

   // Open multi-byte sequence.
   typedef struct packed {
      logic [1:0]            needed;
      logic [1:0]            taken;
      logic [POINT_BITS-1:0] point;
   } seq_state_type;

   function automatic logic [1:0] point_weight(input logic [POINT_BITS-1:0] cp);
      logic zero_w;
      logic wide_w;
      zero_w = (cp < 21'h00020) || (cp == 21'h0007F)
            || (cp >= 21'h00300 && cp <= 21'h0036F)
            || (cp >= 21'h0200B && cp <= 21'h0200D)
            || (cp == 21'h0FEFF);
      wide_w = (cp >= 21'h01100 && cp <= 21'h0115F)
            || (cp >= 21'h02E80 && cp <= 21'h0303E)
            || (cp >= 21'h03041 && cp <= 21'h033FF)
            || (cp >= 21'h03400 && cp <= 21'h04DBF)
            || (cp >= 21'h04E00 && cp <= 21'h09FFF)
            || (cp >= 21'h0A000 && cp <= 21'h0A4CF)
            || (cp >= 21'h0AC00 && cp <= 21'h0D7A3)
            || (cp >= 21'h0F900 && cp <= 21'h0FAFF)
            || (cp >= 21'h0FE30 && cp <= 21'h0FE4F)
            || (cp >= 21'h0FF00 && cp <= 21'h0FF60)
            || (cp >= 21'h0FFE0 && cp <= 21'h0FFE6)
            || (cp >= 21'h20000 && cp <= 21'h2FFFD)
            || (cp >= 21'h30000 && cp <= 21'h3FFFD);
      if (zero_w) begin
         return 2'd0;
      end else if (wide_w) begin
         return 2'd2;
      end
      return 2'd1;
   endfunction

endpackage

// ----- rtl/utf8_display_width_core.sv -----
// Top level: UTF-8 string display width, one byte per cycle.
// Path: a request is registered in the input register and decoded from there; rsp_tvalid
// rises once the total for the final byte (marked by req_tlast) is written to the result register.
// Throughput: one byte per cycle; the input register stalls only on a final byte while
// an earlier total still waits in the result register.
// Reset: synchronous; clears the open sequence, running total and both valid flags.
module utf8_display_width_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [19:0] total_width, [23:20] zero
);

   // Input register: hold one request for the decode stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // Open sequence state.
   utf8w_pkg::seq_state_type seq_ff, seq_in;
   utf8w_pkg::seq_state_type step_next;

   logic [utf8w_pkg::DELTA_BITS-1:0]  step_delta;
   logic                              out_free;
   logic                              stage_go;
   logic [utf8w_pkg::RESULT_BITS-1:0] rsp_width;

   // Advance the decode stage unless a final byte must wait for the result register.
   assign stage_go   = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || stage_go;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
      seq_in = stage_go ? step_next : seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         seq_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         seq_ff      <= seq_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   utf8w_step u_step (
      .cur_state   (seq_ff),
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .next_state  (step_next),
      .delta       (step_delta)
   );

   utf8w_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step_go   (stage_go),
      .step_last (in_last_ff),
      .delta     (step_delta),
      .out_free  (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_width (rsp_width)
   );

   // Pad the total to whole bytes.
   assign rsp_tdata = {4'd0, rsp_width};

endmodule

// ----- rtl/utf8w_step.sv -----
// Per-byte decode: next sequence state and the columns this byte adds.
module utf8w_step (
   input  utf8w_pkg::seq_state_type               cur_state,
   input  logic [7:0]                             text_byte,
   input  logic                                   end_of_text,
   output utf8w_pkg::seq_state_type               next_state,
   output logic [utf8w_pkg::DELTA_BITS-1:0]       delta
);

   utf8w_pkg::seq_state_type after_byte;
   logic                                  is_cont;
   logic [utf8w_pkg::POINT_BITS-1:0]      shifted_point;
   logic [utf8w_pkg::DELTA_BITS-1:0]      seq_delta;
   logic [utf8w_pkg::DELTA_BITS-1:0]      lead_delta;
   logic [utf8w_pkg::DELTA_BITS-1:0]      trunc_delta;
   utf8w_pkg::seq_state_type              lead_state;

   assign is_cont = (text_byte & utf8w_pkg::CONT_MASK) == utf8w_pkg::CONT_CODE;
   assign shifted_point = {cur_state.point[utf8w_pkg::POINT_BITS-7:0],
                           text_byte[5:0] & utf8w_pkg::PAYLOAD_MASK[5:0]};

   // Byte taken as a new lead.
   always_comb begin
      lead_state = '0;
      lead_delta = '0;
      if (!text_byte[7]) begin
         lead_delta = {1'b0, utf8w_pkg::point_weight({13'd0, text_byte})};
      end else if ((text_byte & utf8w_pkg::LEAD2_MASK) == utf8w_pkg::LEAD2_CODE) begin
         lead_state.needed = 2'd1;
         lead_state.point  = {16'd0, text_byte[4:0]};
      end else if ((text_byte & utf8w_pkg::LEAD3_MASK) == utf8w_pkg::LEAD3_CODE) begin
         lead_state.needed = 2'd2;
         lead_state.point  = {17'd0, text_byte[3:0]};
      end else if ((text_byte & utf8w_pkg::LEAD4_MASK) == utf8w_pkg::LEAD4_CODE) begin
         lead_state.needed = 2'd3;
         lead_state.point  = {18'd0, text_byte[2:0]};
      end else begin
         lead_delta = 3'd1;
      end
   end

   always_comb begin
      after_byte = lead_state;
      seq_delta  = lead_delta;
      if (cur_state.needed != 2'd0) begin
         if (is_cont) begin
            seq_delta = '0;
            if (cur_state.needed == 2'd1) begin
               after_byte = '0;
               seq_delta  = {1'b0, utf8w_pkg::point_weight(shifted_point)};
            end else begin
               after_byte.needed = cur_state.needed - 2'd1;
               after_byte.taken  = cur_state.taken + 2'd1;
               after_byte.point  = shifted_point;
            end
         end else begin
            // broken sequence: count lead plus continuations, then re-decode
            seq_delta = lead_delta + 3'd1 + {1'b0, cur_state.taken};
         end
      end
   end

   // Truncated sequence at the end of the string.
   assign trunc_delta = (end_of_text && after_byte.needed != 2'd0)
                        ? 3'd1 + {1'b0, after_byte.taken} : 3'd0;
   assign delta       = seq_delta + trunc_delta;
   assign next_state  = end_of_text ? '0 : after_byte;

endmodule

// ----- rtl/utf8w_accum.sv -----
// Saturating width accumulator and result register.
module utf8w_accum (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step_go,
   input  logic                                   step_last,
   input  logic [utf8w_pkg::DELTA_BITS-1:0]       delta,
   output logic                                   out_free,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [utf8w_pkg::RESULT_BITS-1:0]      rsp_width
);

   logic [utf8w_pkg::TOTAL_BITS-1:0] running_ff, running_in;
   logic [utf8w_pkg::TOTAL_BITS:0]   sum;
   logic [utf8w_pkg::TOTAL_BITS-1:0] sat_sum;
   logic                             valid_ff, valid_in;
   logic [utf8w_pkg::RESULT_BITS-1:0] width_ff, width_in;

   assign sum     = {1'b0, running_ff}
                  + {{(utf8w_pkg::TOTAL_BITS + 1 - utf8w_pkg::DELTA_BITS){1'b0}}, delta};
   assign sat_sum = sum[utf8w_pkg::TOTAL_BITS] ? '1 : sum[utf8w_pkg::TOTAL_BITS-1:0];
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      running_in = running_ff;
      valid_in   = valid_ff && !rsp_ready;
      width_in   = width_ff;
      if (step_go) begin
         running_in = step_last ? '0 : sat_sum;
         if (step_last) begin
            valid_in = 1'b1;
            width_in = utf8w_pkg::RESULT_BITS'(sat_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         running_ff <= running_in;
         valid_ff   <= valid_in;
      end
      width_ff <= width_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_width = width_ff;

endmodule

// ----- tb/utf8_display_width_core_tb.sv -----
// Self-checking bench for the UTF-8 display width core: directed and random strings.
module utf8_display_width_core_tb;

   // A run with no handshake for this many cycles is a hang.
   localparam int QUIET_LIMIT = 4000;
   // Rough request count per idling phase.
   localparam int PHASE_ITEMS = 617;
   // Long receiver hold-off, so the core fills up and back-pressures requests.
   localparam int HOLD_CYCLES = 300;
   // Cycles to linger after the last total.
   localparam int TAIL_CYCLES = 8;
   localparam int WIDE_SPANS = 13;
   localparam int ALL_SPANS = 18;
   localparam logic [utf8w_pkg::TOTAL_BITS:0] WIDTH_CAP =
      {1'b0, {utf8w_pkg::TOTAL_BITS{1'b1}}};

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] text_byte
   logic        req_tlast = 1'b0;     // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [19:0] total_width, [23:20] zero

   utf8_display_width_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   text_item_type                     pending_bytes[$];   // requests not yet offered
   logic [7:0]                        text_buf[$];        // string being assembled
   logic [utf8w_pkg::RESULT_BITS-1:0] width_due[$];       // totals still to arrive

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   mismatches = 0;
   logic req_took = 1'b0;
   logic stall_go = 1'b0;
   logic stall_done = 1'b0;
   int   hold_left = 0;

   // Shadow decoder state.
   logic [1:0]                       conts_left = '0;
   logic [1:0]                       conts_taken = '0;
   logic [utf8w_pkg::POINT_BITS-1:0] point_acc = '0;
   logic [utf8w_pkg::TOTAL_BITS-1:0] width_acc = '0;

   // Append to the tail of each queue.
   task automatic add_request(input text_item_type item);
      pending_bytes.insert(pending_bytes.size(), item);
   endtask

   task automatic add_text_byte(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   task automatic expect_total(input logic [utf8w_pkg::RESULT_BITS-1:0] w);
      width_due.insert(width_due.size(), w);
   endtask

   // Code point spans as {low, high}: wide spans first, then zero-width ones.
   function automatic logic [41:0] range_span(input int idx);
      case (idx)
         0:  return {21'h01100, 21'h0115F};
         1:  return {21'h02E80, 21'h0303E};
         2:  return {21'h03041, 21'h033FF};
         3:  return {21'h03400, 21'h04DBF};
         4:  return {21'h04E00, 21'h09FFF};
         5:  return {21'h0A000, 21'h0A4CF};
         6:  return {21'h0AC00, 21'h0D7A3};
         7:  return {21'h0F900, 21'h0FAFF};
         8:  return {21'h0FE30, 21'h0FE4F};
         9:  return {21'h0FF00, 21'h0FF60};
         10: return {21'h0FFE0, 21'h0FFE6};
         11: return {21'h20000, 21'h2FFFD};
         12: return {21'h30000, 21'h3FFFD};
         13: return {21'h00000, 21'h0001F};
         14: return {21'h0007F, 21'h0007F};
         15: return {21'h00300, 21'h0036F};
         16: return {21'h0200B, 21'h0200D};
         default: return {21'h0FEFF, 21'h0FEFF};
      endcase
   endfunction

   function automatic logic [1:0] column_weight(input logic [utf8w_pkg::POINT_BITS-1:0] cp);
      logic [41:0] span;
      for (int i = 0; i < ALL_SPANS; i++) begin
         span = range_span(i);
         if (cp >= span[41:21] && cp <= span[20:0]) begin
            return (i < WIDE_SPANS) ? 2'd2 : 2'd0;
         end
      end
      return 2'd1;
   endfunction

   function automatic int natural_len(input logic [utf8w_pkg::POINT_BITS-1:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   // Add columns, clamping at the counter maximum.
   task automatic add_columns(input int cols);
      logic [utf8w_pkg::TOTAL_BITS:0] sum;
      sum = {1'b0, width_acc} + (utf8w_pkg::TOTAL_BITS + 1)'(cols);
      width_acc = (sum > WIDTH_CAP) ? WIDTH_CAP[utf8w_pkg::TOTAL_BITS-1:0]
                                    : sum[utf8w_pkg::TOTAL_BITS-1:0];
   endtask

   task automatic drop_sequence();
      conts_left = '0;
      conts_taken = '0;
      point_acc = '0;
   endtask

   task automatic open_or_count(input logic [7:0] b);
      if (b < 8'h80) begin
         add_columns(int'(column_weight({13'b0, b})));
      end else if ((b & utf8w_pkg::LEAD2_MASK) == utf8w_pkg::LEAD2_CODE) begin
         conts_left = 2'd1; conts_taken = 2'd0;
         point_acc = {13'b0, b & ~utf8w_pkg::LEAD2_MASK};
      end else if ((b & utf8w_pkg::LEAD3_MASK) == utf8w_pkg::LEAD3_CODE) begin
         conts_left = 2'd2; conts_taken = 2'd0;
         point_acc = {13'b0, b & ~utf8w_pkg::LEAD3_MASK};
      end else if ((b & utf8w_pkg::LEAD4_MASK) == utf8w_pkg::LEAD4_CODE) begin
         conts_left = 2'd3; conts_taken = 2'd0;
         point_acc = {13'b0, b & ~utf8w_pkg::LEAD4_MASK};
      end else begin
         // stray continuation or a byte F8-FF
         add_columns(1);
      end
   endtask

   // Advance the shadow decoder by one accepted request; queue a total on end of text.
   task automatic take_byte(input logic [7:0] b, input logic last);
      if (conts_left != 0) begin
         if ((b & utf8w_pkg::CONT_MASK) == utf8w_pkg::CONT_CODE) begin
            point_acc = {point_acc[utf8w_pkg::POINT_BITS-7:0], b[5:0]};
            conts_taken = conts_taken + 2'd1;
            conts_left = conts_left - 2'd1;
            if (conts_left == 0) begin
               add_columns(int'(column_weight(point_acc)));
               drop_sequence();
            end
         end else begin
            // broken sequence: charge lead and taken continuations, retry byte as lead
            add_columns(1 + int'(conts_taken));
            drop_sequence();
            open_or_count(b);
         end
      end else begin
         open_or_count(b);
      end
      if (last) begin
         if (conts_left != 0) add_columns(1 + int'(conts_taken));
         expect_total(width_acc[utf8w_pkg::RESULT_BITS-1:0]);
         drop_sequence();
         width_acc = '0;
      end
   endtask

   task automatic note_mismatch(input string what, input int unsigned exp_v,
                                input int unsigned act_v);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %s: expected %0d (0x%h), got %0d (0x%h)",
                  what, exp_v, exp_v, act_v, act_v);
      end
   endtask

   // Move the assembled string to the request queue, marking its final byte.
   task automatic close_text();
      text_item_type item;
      for (int i = 0; i < text_buf.size(); i++) begin
         item.text_byte = text_buf[i];
         item.end_of_text = (i == text_buf.size() - 1);
         add_request(item);
      end
      text_buf.delete();
   endtask

   // Encode cp in n bytes (overlong if n exceeds its natural length); keep the first bytes.
   task automatic put_point(input logic [utf8w_pkg::POINT_BITS-1:0] cp, input int n,
                            input int keep);
      logic [7:0] unit [0:3];
      case (n)
         1: unit[0] = {1'b0, cp[6:0]};
         2: begin
            unit[0] = {3'b110, cp[10:6]};
            unit[1] = {2'b10, cp[5:0]};
         end
         3: begin
            unit[0] = {4'b1110, cp[15:12]};
            unit[1] = {2'b10, cp[11:6]};
            unit[2] = {2'b10, cp[5:0]};
         end
         default: begin
            unit[0] = {5'b11110, cp[20:18]};
            unit[1] = {2'b10, cp[17:12]};
            unit[2] = {2'b10, cp[11:6]};
            unit[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) add_text_byte(unit[i]);
   endtask

   // Favor span boundaries, else any code point of a random encoded length.
   function automatic logic [utf8w_pkg::POINT_BITS-1:0] pick_point();
      logic [41:0]                      span;
      logic [utf8w_pkg::POINT_BITS-1:0] base;
      int                               n;
      if ($urandom_range(99) < 45) begin
         span = range_span($urandom_range(ALL_SPANS - 1));
         base = $urandom_range(1) ? span[20:0] : span[41:21];
         return base + utf8w_pkg::POINT_BITS'($urandom_range(2)) - 1'b1;
      end
      n = $urandom_range(1, 4);
      case (n)
         1: return utf8w_pkg::POINT_BITS'($urandom & 32'h7F);
         2: return utf8w_pkg::POINT_BITS'($urandom & 32'h7FF);
         3: return utf8w_pkg::POINT_BITS'($urandom & 32'hFFFF);
         default: return utf8w_pkg::POINT_BITS'($urandom & 32'h1FFFFF);
      endcase
   endfunction

   // Mostly well-formed characters, some cut short, some raw noise bytes.
   task automatic random_text();
      logic [utf8w_pkg::POINT_BITS-1:0] cp;
      int                               chars;
      int                               kind;
      int                               n;
      chars = $urandom_range(1, 8);
      for (int c = 0; c < chars; c++) begin
         kind = $urandom_range(99);
         cp = pick_point();
         n = natural_len(cp);
         if (kind < 70) begin
            if ($urandom_range(9) == 0) n = $urandom_range(n, 4);
            put_point(cp, n, n);
         end else if (kind < 84) begin
            n = $urandom_range((n < 2) ? 2 : n, 4);
            put_point(cp, n, $urandom_range(1, n - 1));
         end else begin
            add_text_byte(8'($urandom_range(255)));
         end
      end
      close_text();
   endtask

   // Request driver: offer the next byte at the falling edge, hold until accepted.
   always @(negedge clock) begin
      text_item_type next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next.text_byte;
            req_tlast <= next.end_of_text;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side: random ready, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_go && !stall_done) begin
         stall_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on each accepted request, check each accepted total.
   always @(posedge clock) begin
      logic [utf8w_pkg::RESULT_BITS-1:0] want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (width_due.size() == 0) begin
               note_mismatch("unexpected total_width", 0, 32'(rsp_tdata[19:0]));
            end else begin
               want = width_due.pop_front();
               if (rsp_tdata[19:0] !== want) begin
                  note_mismatch("total_width", 32'(want), 32'(rsp_tdata[19:0]));
               end
               if (rsp_tdata[23:20] !== 4'h0) begin
                  note_mismatch("pad bits", 0, 32'(rsp_tdata[23:20]));
               end
            end
         end
      end
   end

   // Watchdog: end the run after too long with no handshake on either side.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 19; recv_idle_pct = 71; end
            1: begin send_idle_pct = 71; recv_idle_pct = 19; end
            default: begin
               send_idle_pct = 0; recv_idle_pct = 0;
               stall_go = 1'b1;
            end
         endcase
         if (phase == 0) begin
            add_text_byte(8'h41); close_text();                              // plain ASCII
            add_text_byte(8'h00); close_text();                              // control
            add_text_byte(8'h7F); close_text();                              // DEL
            add_text_byte(8'hFF); close_text();                              // stray high byte
            add_text_byte(8'h80); close_text();                              // lone continuation
            put_point(21'h00300, 2, 2); close_text();                        // combining mark
            put_point(21'h04E00, 3, 3); close_text();                        // CJK wide
            put_point(21'h20000, 4, 4); close_text();                        // plane 2 wide
            put_point(21'h0FEFF, 3, 3); close_text();                        // BOM
            put_point(21'h04E00, 3, 2); add_text_byte(8'h41); close_text();  // broken
            put_point(21'h1F600, 4, 3); close_text();                        // truncated
         end
         while (pending_bytes.size() < PHASE_ITEMS) random_text();
         while (pending_bytes.size() != 0) @(posedge clock);
      end

      while (req_tvalid) @(posedge clock);
      while (width_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && width_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
